/* design/cbq_pkg.sv */
// Shared types, constants and the microcode program of the cascaded biquad low-pass.
// Used by cbq_sequencer, cbq_datapath and cascaded_biquad_lowpass.
package cbq_pkg;

   localparam int COEF_W     = 24;   // Q2.21 coefficient width
   localparam int SPLIT_W    = 24;   // low partial-product slice of a multiplier operand
   localparam int STEP_W     = 4;
   localparam int SEC_W      = 2;
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   localparam logic [SEC_W-1:0] SEC_FIRST = 2'd0;
   localparam logic [SEC_W-1:0] SEC_LAST  = 2'd2;

   // register indexes, byte address is 4 * index
   localparam logic [2:0] REG_FEEDBACK1_HIGH = 3'd0;
   localparam logic [2:0] REG_FEEDBACK2_HIGH = 3'd1;
   localparam logic [2:0] REG_GAIN_MID       = 3'd2;
   localparam logic [2:0] REG_FEEDBACK1_LOW  = 3'd3;
   localparam logic [2:0] REG_FEEDBACK2_LOW  = 3'd4;
   localparam logic [2:0] REG_GAIN_OUT       = 3'd5;

   typedef struct packed {
      logic signed [COEF_W-1:0] feedback1_high;
      logic signed [COEF_W-1:0] feedback2_high;
      logic signed [COEF_W-1:0] gain_mid;
      logic signed [COEF_W-1:0] feedback1_low;
      logic signed [COEF_W-1:0] feedback2_low;
      logic signed [COEF_W-1:0] gain_out;
   } coef_set_type;

   localparam coef_set_type COEF_RESET = '{
      feedback1_high: -24'sd988597,
      feedback2_high:  24'sd1073113,
      gain_mid:        24'sd1090938,
      feedback1_low:  -24'sd2328677,
      feedback2_low:   24'sd1093665,
      gain_out:        24'sd431174
   };

   typedef enum logic [1:0] {SRC_W1, SRC_W2, SRC_SUM} mul_src_type;
   typedef enum logic       {HALF_HI, HALF_LO} mul_half_type;
   typedef enum logic [1:0] {CSEL_A1, CSEL_A2, CSEL_G} coef_sel_type;
   typedef enum logic [1:0] {ACC_HOLD, ACC_LOAD_HI, ACC_ADD} acc_op_type;
   typedef enum logic [1:0] {RND_HOLD, RND_FB, RND_GAIN} rnd_op_type;

   // one control word of the program
   typedef struct packed {
      mul_src_type       mul_src;
      mul_half_type      mul_half;
      coef_sel_type      coef_sel;
      acc_op_type        acc_op;
      rnd_op_type        rnd_op;
      logic              fb_load;   // fb <= rounded first feedback product
      logic              feed;      // section input <= saturated previous feed
      logic              w_calc;    // w <= sat(in - fb - rnd)
      logic              sum_upd;   // form doubled sum, rotate node line
      logic              branch;    // next section unless last
      logic              finish;    // hand result to output register
      logic [STEP_W-1:0] target;
   } uword_type;

   typedef struct packed {
      uword_type        uw;
      logic [SEC_W-1:0] sec;
   } dp_ctrl_type;

   localparam logic [STEP_W-1:0] ST_W1_HI   = 4'd0;
   localparam logic [STEP_W-1:0] ST_W1_LO   = 4'd1;
   localparam logic [STEP_W-1:0] ST_W2_HI   = 4'd2;
   localparam logic [STEP_W-1:0] ST_W2_LO   = 4'd3;
   localparam logic [STEP_W-1:0] ST_FB_ACC  = 4'd4;
   localparam logic [STEP_W-1:0] ST_FB_RND  = 4'd5;
   localparam logic [STEP_W-1:0] ST_NODE    = 4'd6;
   localparam logic [STEP_W-1:0] ST_SUM     = 4'd7;
   localparam logic [STEP_W-1:0] ST_G_HI    = 4'd8;
   localparam logic [STEP_W-1:0] ST_G_LO    = 4'd9;
   localparam logic [STEP_W-1:0] ST_G_ACC   = 4'd10;
   localparam logic [STEP_W-1:0] ST_G_RND   = 4'd11;
   localparam logic [STEP_W-1:0] ST_FINISH  = 4'd12;

   localparam uword_type UW_NOP = '{
      mul_src:  SRC_W1,
      mul_half: HALF_HI,
      coef_sel: CSEL_A1,
      acc_op:   ACC_HOLD,
      rnd_op:   RND_HOLD,
      fb_load:  1'b0,
      feed:     1'b0,
      w_calc:   1'b0,
      sum_upd:  1'b0,
      branch:   1'b0,
      finish:   1'b0,
      target:   ST_W1_HI
   };

   // Program ROM. The multiplier product is registered, so the accumulator takes each
   // product in the step after its issue and works behind the multiplier.
   function automatic uword_type ucode(input logic [STEP_W-1:0] step);
      uword_type w;
      w = UW_NOP;
      unique case (step)
         ST_W1_HI: begin
            w.mul_src  = SRC_W1;
            w.mul_half = HALF_HI;
            w.coef_sel = CSEL_A1;
            w.feed     = 1'b1;
         end
         ST_W1_LO: begin
            w.mul_src  = SRC_W1;
            w.mul_half = HALF_LO;
            w.coef_sel = CSEL_A1;
            w.acc_op   = ACC_LOAD_HI;
         end
         ST_W2_HI: begin
            w.mul_src  = SRC_W2;
            w.mul_half = HALF_HI;
            w.coef_sel = CSEL_A2;
            w.acc_op   = ACC_ADD;
         end
         ST_W2_LO: begin
            w.mul_src  = SRC_W2;
            w.mul_half = HALF_LO;
            w.coef_sel = CSEL_A2;
            w.acc_op   = ACC_LOAD_HI;
            w.rnd_op   = RND_FB;
         end
         ST_FB_ACC: begin
            w.acc_op  = ACC_ADD;
            w.fb_load = 1'b1;
         end
         ST_FB_RND: begin
            w.rnd_op = RND_FB;
         end
         ST_NODE: begin
            w.w_calc = 1'b1;
         end
         ST_SUM: begin
            w.sum_upd = 1'b1;
         end
         ST_G_HI: begin
            w.mul_src  = SRC_SUM;
            w.mul_half = HALF_HI;
            w.coef_sel = CSEL_G;
         end
         ST_G_LO: begin
            w.mul_src  = SRC_SUM;
            w.mul_half = HALF_LO;
            w.coef_sel = CSEL_G;
            w.acc_op   = ACC_LOAD_HI;
         end
         ST_G_ACC: begin
            w.acc_op = ACC_ADD;
         end
         ST_G_RND: begin
            w.rnd_op = RND_GAIN;
            w.branch = 1'b1;
            w.target = ST_W1_HI;
         end
         ST_FINISH: begin
            w.finish = 1'b1;
         end
         default: begin
            w = UW_NOP;
         end
      endcase
      return w;
   endfunction

endpackage

/* design/cbq_sequencer.sv */
// Microcode sequencer: step counter, section counter and program ROM lookup.
// Depends on cbq_pkg for the control word layout and the program.
module cbq_sequencer (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic                out_free,
   output cbq_pkg::dp_ctrl_type ctrl,
   output logic                idle,
   output logic                done
);
   import cbq_pkg::*;

   typedef enum logic [1:0] {
      SEQ_IDLE = 2'b01,
      SEQ_RUN  = 2'b10
   } seq_state_type;

   seq_state_type     state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [SEC_W-1:0]  sec_ff, sec_in;
   uword_type         uw;

   assign uw = ucode(step_ff);

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      sec_in   = sec_ff;
      unique case (state_ff)
         SEQ_IDLE: begin
            if (start) begin
               state_in = SEQ_RUN;
               step_in  = ST_W1_HI;
               sec_in   = SEC_FIRST;
            end
         end
         SEQ_RUN: begin
            priority if (uw.finish) begin
               // hold on the last step until the output register has room
               if (out_free) begin
                  state_in = SEQ_IDLE;
               end
            end else if (uw.branch && (sec_ff != SEC_LAST)) begin
               step_in = uw.target;
               sec_in  = sec_ff + 1'b1;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         default: begin
            state_in = SEQ_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SEQ_IDLE;
         step_ff  <= ST_W1_HI;
         sec_ff   <= SEC_FIRST;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         sec_ff   <= sec_in;
      end
   end

   assign ctrl.uw  = (state_ff == SEQ_RUN) ? uw : UW_NOP;
   assign ctrl.sec = sec_ff;
   assign idle     = (state_ff == SEQ_IDLE);
   assign done     = (state_ff == SEQ_RUN) && uw.finish && out_free;

endmodule

/* design/cbq_datapath.sv */
// Shared multiply-accumulate datapath with rounding, saturation and the node line.
// Depends on cbq_pkg; driven one control word per cycle by cbq_sequencer.
module cbq_datapath #(
   parameter int SAMPLE_WIDTH  = 24,
   parameter int NODE_WIDTH    = 32,
   parameter int COEF_FRACTION = 21
) (
   input  logic                           clock,
   input  logic                           reset,
   input  cbq_pkg::dp_ctrl_type           ctrl,
   input  cbq_pkg::coef_set_type          coef,
   input  logic                           load_sample,
   input  logic signed [SAMPLE_WIDTH-1:0] sample_in,
   output logic signed [SAMPLE_WIDTH-1:0] sample_out
);
   import cbq_pkg::*;

   localparam int OP_W    = NODE_WIDTH + 2;
   localparam int HI_W    = OP_W - SPLIT_W;
   localparam int MUL_A_W = (SPLIT_W + 1 > HI_W) ? SPLIT_W + 1 : HI_W;
   localparam int PROD_W  = MUL_A_W + COEF_W;
   localparam int ACC_W   = OP_W + COEF_W;
   localparam int RND_W   = ACC_W + 1;
   localparam int DIF_W   = RND_W + 2;

   localparam logic signed [RND_W-1:0] HALF_F =
      {{(RND_W - COEF_FRACTION){1'b0}}, 1'b1, {(COEF_FRACTION - 1){1'b0}}};
   localparam logic signed [RND_W-1:0] HALF_G =
      {{(RND_W - COEF_FRACTION - 1){1'b0}}, 1'b1, {COEF_FRACTION{1'b0}}};
   localparam logic signed [RND_W-1:0] HALF_F_M1 = HALF_F - RND_W'(1);
   localparam logic signed [RND_W-1:0] HALF_G_M1 = HALF_G - RND_W'(1);

   localparam logic signed [RND_W-1:0] NODE_MAX_R =
      {{(RND_W - NODE_WIDTH + 1){1'b0}}, {(NODE_WIDTH - 1){1'b1}}};
   localparam logic signed [RND_W-1:0] NODE_MIN_R = ~NODE_MAX_R;
   localparam logic signed [RND_W-1:0] SAMP_MAX_R =
      {{(RND_W - SAMPLE_WIDTH + 1){1'b0}}, {(SAMPLE_WIDTH - 1){1'b1}}};
   localparam logic signed [RND_W-1:0] SAMP_MIN_R = ~SAMP_MAX_R;
   localparam logic signed [DIF_W-1:0] NODE_MAX_D =
      {{(DIF_W - NODE_WIDTH + 1){1'b0}}, {(NODE_WIDTH - 1){1'b1}}};
   localparam logic signed [DIF_W-1:0] NODE_MIN_D = ~NODE_MAX_D;

   // node line: position 0 holds the section being worked on until its sum step rotates the line
   logic signed [NODE_WIDTH-1:0] recent_ff [3];
   logic signed [NODE_WIDTH-1:0] recent_in [3];
   logic signed [NODE_WIDTH-1:0] older_ff  [3];
   logic signed [NODE_WIDTH-1:0] older_in  [3];

   logic signed [NODE_WIDTH-1:0] in_ff, in_in;
   logic signed [NODE_WIDTH-1:0] w_ff, w_in;
   logic signed [OP_W-1:0]       sum_ff, sum_in;
   logic signed [PROD_W-1:0]     prod_ff, prod_in;
   logic signed [ACC_W-1:0]      acc_ff, acc_in;
   logic signed [RND_W-1:0]      rnd_ff, rnd_in;
   logic signed [RND_W-1:0]      fb_ff, fb_in;

   logic signed [OP_W-1:0]       opnd;
   logic signed [HI_W-1:0]       op_hi;
   logic [SPLIT_W-1:0]           op_lo;
   logic signed [MUL_A_W-1:0]    mul_a;
   logic signed [COEF_W-1:0]     mul_c;
   logic                         sec_high;
   logic signed [ACC_W-1:0]      prod_ext;
   logic signed [RND_W-1:0]      acc_ext;
   logic signed [RND_W-1:0]      bias;
   logic signed [RND_W-1:0]      rsum;
   logic signed [RND_W-1:0]      rnd_val;
   logic signed [NODE_WIDTH-1:0] feed_sat;
   logic signed [DIF_W-1:0]      diff;
   logic signed [NODE_WIDTH-1:0] w_sat;

   assign sec_high = (ctrl.sec != SEC_LAST);

   // multiplier operand and coefficient selection
   always_comb begin
      unique case (ctrl.uw.mul_src)
         SRC_W1:  opnd = OP_W'(recent_ff[0]);
         SRC_W2:  opnd = OP_W'(older_ff[0]);
         default: opnd = sum_ff;
      endcase
      op_hi = opnd[OP_W-1:SPLIT_W];
      op_lo = opnd[SPLIT_W-1:0];
      mul_a = (ctrl.uw.mul_half == HALF_HI) ? MUL_A_W'(op_hi) : MUL_A_W'(op_lo);
      unique case (ctrl.uw.coef_sel)
         CSEL_A1: mul_c = sec_high ? coef.feedback1_high : coef.feedback1_low;
         CSEL_A2: mul_c = sec_high ? coef.feedback2_high : coef.feedback2_low;
         default: mul_c = sec_high ? coef.gain_mid : coef.gain_out;
      endcase
   end

   assign prod_in  = mul_a * mul_c;
   assign prod_ext = ACC_W'(prod_ff);

   always_comb begin
      unique case (ctrl.uw.acc_op)
         ACC_LOAD_HI: acc_in = prod_ext <<< SPLIT_W;
         ACC_ADD:     acc_in = acc_ff + prod_ext;
         default:     acc_in = acc_ff;
      endcase
   end

   // round half away from zero: a negative value takes one less of bias
   always_comb begin
      acc_ext = RND_W'(acc_ff);
      if (ctrl.uw.rnd_op == RND_GAIN) begin
         bias = acc_ff[ACC_W-1] ? HALF_G_M1 : HALF_G;
      end else begin
         bias = acc_ff[ACC_W-1] ? HALF_F_M1 : HALF_F;
      end
      rsum = acc_ext + bias;
      if (ctrl.uw.rnd_op == RND_GAIN) begin
         rnd_val = rsum >>> (COEF_FRACTION + 1);
      end else begin
         rnd_val = rsum >>> COEF_FRACTION;
      end
      priority if (load_sample) begin
         rnd_in = RND_W'(sample_in);
      end else if (ctrl.uw.rnd_op != RND_HOLD) begin
         rnd_in = rnd_val;
      end else begin
         rnd_in = rnd_ff;
      end
   end

   always_comb begin
      priority if (rnd_ff > NODE_MAX_R) begin
         feed_sat = NODE_WIDTH'(NODE_MAX_R);
      end else if (rnd_ff < NODE_MIN_R) begin
         feed_sat = NODE_WIDTH'(NODE_MIN_R);
      end else begin
         feed_sat = NODE_WIDTH'(rnd_ff);
      end
      priority if (rnd_ff > SAMP_MAX_R) begin
         sample_out = SAMPLE_WIDTH'(SAMP_MAX_R);
      end else if (rnd_ff < SAMP_MIN_R) begin
         sample_out = SAMPLE_WIDTH'(SAMP_MIN_R);
      end else begin
         sample_out = SAMPLE_WIDTH'(rnd_ff);
      end
   end

   // new node: w = in - (first feedback term) - (second feedback term)
   always_comb begin
      diff = DIF_W'(in_ff) - DIF_W'(fb_ff) - DIF_W'(rnd_ff);
      priority if (diff > NODE_MAX_D) begin
         w_sat = NODE_WIDTH'(NODE_MAX_D);
      end else if (diff < NODE_MIN_D) begin
         w_sat = NODE_WIDTH'(NODE_MIN_D);
      end else begin
         w_sat = NODE_WIDTH'(diff);
      end
   end

   always_comb begin
      fb_in = ctrl.uw.fb_load ? rnd_ff : fb_ff;
      in_in = ctrl.uw.feed ? feed_sat : in_ff;
      w_in  = ctrl.uw.w_calc ? w_sat : w_ff;
      sum_in = sum_ff;
      for (int i = 0; i < 3; i++) begin
         recent_in[i] = recent_ff[i];
         older_in[i]  = older_ff[i];
      end
      if (ctrl.uw.sum_upd) begin
         sum_in = (OP_W'(recent_ff[0]) <<< 1) + OP_W'(w_ff) + OP_W'(older_ff[0]);
         // rotate so the next section's nodes come to position 0
         recent_in[0] = recent_ff[1];
         recent_in[1] = recent_ff[2];
         recent_in[2] = w_ff;
         older_in[0]  = older_ff[1];
         older_in[1]  = older_ff[2];
         older_in[2]  = recent_ff[0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 3; i++) begin
            recent_ff[i] <= '0;
            older_ff[i]  <= '0;
         end
      end else begin
         for (int i = 0; i < 3; i++) begin
            recent_ff[i] <= recent_in[i];
            older_ff[i]  <= older_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      in_ff   <= in_in;
      w_ff    <= w_in;
      sum_ff  <= sum_in;
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
      rnd_ff  <= rnd_in;
      fb_ff   <= fb_in;
   end

endmodule

/* design/cascaded_biquad_lowpass.sv */
// Top level of the three-section cascaded biquad low-pass: stream ports,
// register file and output register. Uses cbq_pkg, cbq_sequencer, cbq_datapath.
//
//   port group | dir    | carries
//   -----------+--------+-------------------------------------------
//   req_*      | in     | one signed sample per transfer
//   rsp_*      | out    | one filtered, saturated sample per transfer
//   csr_*      | in/out | six Q2.21 coefficients at byte address 4*i
//
// A sample reaches the output register after twelve program steps for each of the
// three sections on the single shared multiplier and a final hand-off step. A new
// sample is accepted only while the program is idle, after the last result has
// been handed off.
// Reset clears the filter nodes and loads the default coefficients.
// A pending result in the output register does not block acceptance; only a
// second finished result waiting on a full output register stalls the program.
module cascaded_biquad_lowpass #(
   parameter int SAMPLE_WIDTH  = 24,
   parameter int NODE_WIDTH    = 32,
   parameter int COEF_FRACTION = 21
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_tvalid,
   output logic                                    req_tready,
   input  logic [((SAMPLE_WIDTH + 7) / 8) * 8-1:0] req_tdata,   // sample_in
   output logic                                    rsp_tvalid,
   input  logic                                    rsp_tready,
   output logic [((SAMPLE_WIDTH + 7) / 8) * 8-1:0] rsp_tdata,   // sample_out
   input  logic                                    csr_psel,
   input  logic                                    csr_penable,
   input  logic                                    csr_pwrite,
   input  logic [cbq_pkg::CSR_ADDR_W-1:0]          csr_paddr,
   input  logic [cbq_pkg::CSR_DATA_W-1:0]          csr_pwdata,
   output logic [cbq_pkg::CSR_DATA_W-1:0]          csr_prdata,
   output logic                                    csr_pready
);
   import cbq_pkg::*;

   localparam int DATA_W = ((SAMPLE_WIDTH + 7) / 8) * 8;

   coef_set_type                  coef_ff, coef_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [SAMPLE_WIDTH-1:0]       rsp_data_ff, rsp_data_in;

   logic                          csr_wr;
   logic [2:0]                    csr_idx;
   logic signed [COEF_W-1:0]      csr_wval;
   logic                          req_xfer;
   logic                          out_free;
   logic                          seq_idle;
   logic                          seq_done;
   dp_ctrl_type                   dp_ctrl;
   logic signed [SAMPLE_WIDTH-1:0] sample_in;
   logic signed [SAMPLE_WIDTH-1:0] sample_out;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_idx    = csr_paddr[4:2];
   assign csr_wval   = csr_pwdata[COEF_W-1:0];

   always_comb begin
      coef_in = coef_ff;
      if (csr_wr) begin
         unique case (csr_idx)
            REG_FEEDBACK1_HIGH: coef_in.feedback1_high = csr_wval;
            REG_FEEDBACK2_HIGH: coef_in.feedback2_high = csr_wval;
            REG_GAIN_MID:       coef_in.gain_mid       = csr_wval;
            REG_FEEDBACK1_LOW:  coef_in.feedback1_low  = csr_wval;
            REG_FEEDBACK2_LOW:  coef_in.feedback2_low  = csr_wval;
            REG_GAIN_OUT:       coef_in.gain_out       = csr_wval;
            default:            coef_in = coef_ff;
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         REG_FEEDBACK1_HIGH: csr_prdata = CSR_DATA_W'(coef_ff.feedback1_high);
         REG_FEEDBACK2_HIGH: csr_prdata = CSR_DATA_W'(coef_ff.feedback2_high);
         REG_GAIN_MID:       csr_prdata = CSR_DATA_W'(coef_ff.gain_mid);
         REG_FEEDBACK1_LOW:  csr_prdata = CSR_DATA_W'(coef_ff.feedback1_low);
         REG_FEEDBACK2_LOW:  csr_prdata = CSR_DATA_W'(coef_ff.feedback2_low);
         REG_GAIN_OUT:       csr_prdata = CSR_DATA_W'(coef_ff.gain_out);
         default:            csr_prdata = '0;
      endcase
   end

   assign req_tready = seq_idle;
   assign req_xfer   = req_tvalid && req_tready;
   assign sample_in  = req_tdata[SAMPLE_WIDTH-1:0];
   assign out_free   = !rsp_valid_ff || rsp_tready;

   cbq_sequencer u_seq (
      .clock    (clock),
      .reset    (reset),
      .start    (req_xfer),
      .out_free (out_free),
      .ctrl     (dp_ctrl),
      .idle     (seq_idle),
      .done     (seq_done)
   );

   cbq_datapath #(
      .SAMPLE_WIDTH  (SAMPLE_WIDTH),
      .NODE_WIDTH    (NODE_WIDTH),
      .COEF_FRACTION (COEF_FRACTION)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .ctrl        (dp_ctrl),
      .coef        (coef_ff),
      .load_sample (req_xfer),
      .sample_in   (sample_in),
      .sample_out  (sample_out)
   );

   // output register: load on hand-off, drop after the transfer
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      priority if (seq_done) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = sample_out;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff      <= COEF_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         coef_ff      <= coef_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = DATA_W'(rsp_data_ff);

   // a sample transfer starts the program, so no second one follows at once
   a_accept_starts_run: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> !req_tready)
      else $error("sample accepted while the program did not start");

   // hand-off only into a free output register
   a_done_needs_room: assert property (@(posedge clock) disable iff (reset)
      seq_done |-> (!rsp_valid_ff || rsp_tready))
      else $error("result handed off onto an unsent result");

   // every hand-off shows up as a valid result
   a_done_gives_valid: assert property (@(posedge clock) disable iff (reset)
      seq_done |=> rsp_tvalid)
      else $error("hand-off did not produce a valid result");

   // the program never hands off while the block is idle
   a_done_while_running: assert property (@(posedge clock) disable iff (reset)
      seq_done |-> !req_tready)
      else $error("hand-off while no sample is in progress");

endmodule

/* tb/lowpass_checker.sv */
// Scoreboard for the three-section cascaded biquad low-pass: watches the sample
// streams and the register port, predicts every filtered sample and compares.
// Depends on cbq_pkg for the coefficient set type, its reset value and register indexes.
module lowpass_checker
   import cbq_pkg::*;
#(
   parameter int SAMPLE_W = 24,
   parameter int NODE_W   = 32,
   parameter int FRAC_W   = 21,
   parameter int TDATA_W  = ((SAMPLE_W + 7) / 8) * 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [TDATA_W-1:0]    req_tdata,    // sample_in
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [TDATA_W-1:0]    rsp_tdata,    // sample_out
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   input  logic                  csr_pready,
   output int                    failures,
   output int                    pending,
   output int                    checked
);
   timeunit 1ns;
   timeprecision 1ps;

   coef_set_type               coefs;
   logic signed [NODE_W-1:0]   node_recent [3];
   logic signed [NODE_W-1:0]   node_older [3];
   logic signed [SAMPLE_W-1:0] expected_samples [$];

   function automatic longint clamp_to(longint v, int width);
      longint hi;
      longint lo;
      hi = (longint'(1) << (width - 1)) - 1;
      lo = -hi - 1;
      if (v > hi) return hi;
      if (v < lo) return lo;
      return v;
   endfunction

   // x * c / 2^sh, rounded half away from zero; magnitudes stay well below 2^62
   function automatic longint scale_round(longint x, longint c, int sh);
      longint mag;
      bit     neg;
      neg = (x < 0) != (c < 0);
      mag = ((x < 0 ? -x : x) * (c < 0 ? -c : c) + (longint'(1) << (sh - 1))) >>> sh;
      return neg ? -mag : mag;
   endfunction

   // one direct-form-II section: update its node pair, return the unsaturated feed
   function automatic longint run_section(int k, longint x_in, longint a1, longint a2,
                                          longint g);
      longint w1;
      longint w2;
      longint fb;
      longint w;
      longint sum;
      w1 = node_recent[k];
      w2 = node_older[k];
      fb = scale_round(w1, a1, FRAC_W) + scale_round(w2, a2, FRAC_W);
      w = clamp_to(x_in - fb, NODE_W);
      sum = 2 * w1 + w + w2;
      node_older[k] = w1;
      node_recent[k] = w;
      return scale_round(sum, g, FRAC_W + 1);
   endfunction

   function automatic logic signed [SAMPLE_W-1:0] filter_sample(logic signed [SAMPLE_W-1:0] s);
      longint f1;
      longint f2;
      longint y;
      f1 = clamp_to(run_section(0, s, coefs.feedback1_high, coefs.feedback2_high,
                                coefs.gain_mid), NODE_W);
      f2 = clamp_to(run_section(1, f1, coefs.feedback1_high, coefs.feedback2_high,
                                coefs.gain_mid), NODE_W);
      y = clamp_to(run_section(2, f2, coefs.feedback1_low, coefs.feedback2_low,
                               coefs.gain_out), SAMPLE_W);
      return y[SAMPLE_W-1:0];
   endfunction

   function automatic void store_coef(logic [2:0] index, logic [COEF_W-1:0] value);
      case (index)
         REG_FEEDBACK1_HIGH: coefs.feedback1_high = value;
         REG_FEEDBACK2_HIGH: coefs.feedback2_high = value;
         REG_GAIN_MID:       coefs.gain_mid = value;
         REG_FEEDBACK1_LOW:  coefs.feedback1_low = value;
         REG_FEEDBACK2_LOW:  coefs.feedback2_low = value;
         REG_GAIN_OUT:       coefs.gain_out = value;
         default: ;  // drop writes past the last register
      endcase
   endfunction

   task automatic report_mismatch(string what, logic [SAMPLE_W-1:0] got,
                                  logic [SAMPLE_W-1:0] want);
      failures++;
      $display("%0t ns mismatch: %s: got %0d, predicted %0d", $time, what,
               $signed(got), $signed(want));
   endtask

   always @(posedge clock) begin : watch
      logic signed [SAMPLE_W-1:0] want;
      if (reset) begin
         coefs = COEF_RESET;
         for (int k = 0; k < 3; k++) begin
            node_recent[k] = '0;
            node_older[k] = '0;
         end
         expected_samples.delete();
         failures = 0;
         checked = 0;
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            store_coef(csr_paddr[CSR_ADDR_W-1:2], csr_pwdata[COEF_W-1:0]);
         end
         // retire before predicting, so a result never matches the sample of its own edge
         if (rsp_tvalid && rsp_tready) begin
            if (expected_samples.size() == 0) begin
               report_mismatch("result transfer with no sample outstanding",
                               rsp_tdata[SAMPLE_W-1:0], '0);
            end else begin
               want = expected_samples.pop_front();
               if (rsp_tdata[SAMPLE_W-1:0] !== want) begin
                  report_mismatch("sample_out", rsp_tdata[SAMPLE_W-1:0], want);
               end
               checked++;
            end
         end
         if (req_tvalid && req_tready) begin
            expected_samples.push_back(filter_sample(req_tdata[SAMPLE_W-1:0]));
         end
      end
      pending = expected_samples.size();
   end

endmodule

/* tb/testbench.sv */
// Top of the cascaded biquad low-pass testbench: clock, reset, sample and
// coefficient stimulus, stream idling and the verdict.
// Depends on cbq_pkg, cascaded_biquad_lowpass and lowpass_checker.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import cbq_pkg::*;

   localparam int SAMPLE_W      = 24;
   localparam int TDATA_W       = ((SAMPLE_W + 7) / 8) * 8;
   localparam int SETTLE_CYCLES = 48;
   localparam int RANDOM_COUNT  = 285;   // random samples per coefficient setting

   localparam logic [2:0] REG_SPARE_LO = REG_GAIN_OUT + 3'd1;
   localparam logic [2:0] REG_SPARE_HI = REG_GAIN_OUT + 3'd2;

   localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W - 1){1'b1}}};
   localparam logic [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W - 1){1'b0}}};
   localparam logic [COEF_W-1:0]   COEF_MAX   = {1'b0, {(COEF_W - 1){1'b1}}};
   localparam logic [COEF_W-1:0]   COEF_MIN   = {1'b1, {(COEF_W - 1){1'b0}}};

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [TDATA_W-1:0]    req_tdata = '0;     // sample_in
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [TDATA_W-1:0]    rsp_tdata;          // sample_out
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   int failures;
   int pending_samples;
   int checked_samples;

   int samples_sent = 0;
   int settings_used = 0;
   int burst_left = 0;
   int tx_gap_max = 0;
   int rx_stall_max = 0;
   bit rx_steady = 1'b1;
   int rx_count = 0;
   int drift_level = 0;

   always #5 clock = ~clock;

   cascaded_biquad_lowpass dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   lowpass_checker filter_check (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_pready  (csr_pready),
      .failures    (failures),
      .pending     (pending_samples),
      .checked     (checked_samples)
   );

   // receiver: alternate ready runs and stall runs unless told to stay ready
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (rx_steady) begin
         rsp_tready <= 1'b1;
      end else if (rx_count > 0) begin
         rx_count <= rx_count - 1;
      end else begin
         rsp_tready <= !rsp_tready;
         rx_count <= rsp_tready ? $urandom_range(0, rx_stall_max) : $urandom_range(0, 12);
      end
   end

   task automatic send_sample(input logic [SAMPLE_W-1:0] s);
      int gap;
      req_tvalid <= 1'b1;
      req_tdata <= TDATA_W'(s);
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      samples_sent++;
      if (tx_gap_max > 0) begin
         if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap = $urandom_range(1, tx_gap_max);
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end else begin
            burst_left--;
         end
      end
   endtask

   task automatic write_coef(input logic [2:0] index, input logic [COEF_W-1:0] value);
      logic [CSR_DATA_W-COEF_W-1:0] upper;
      // upper bits are either the sign extension or junk the block must ignore
      upper = $urandom_range(0, 1) ? {(CSR_DATA_W - COEF_W){value[COEF_W-1]}}
                                   : (CSR_DATA_W - COEF_W)'($urandom);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {index, 2'b00};
      csr_pwdata <= {upper, value};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(posedge clock);
   endtask

   task automatic load_coefs(input logic [COEF_W-1:0] f1h, input logic [COEF_W-1:0] f2h,
                             input logic [COEF_W-1:0] gm, input logic [COEF_W-1:0] f1l,
                             input logic [COEF_W-1:0] f2l, input logic [COEF_W-1:0] go);
      write_coef(REG_FEEDBACK1_HIGH, f1h);
      write_coef(REG_FEEDBACK2_HIGH, f2h);
      write_coef(REG_GAIN_MID, gm);
      write_coef(REG_FEEDBACK1_LOW, f1l);
      write_coef(REG_FEEDBACK2_LOW, f2l);
      write_coef(REG_GAIN_OUT, go);
      settings_used++;
   endtask

   // hold off until every predicted sample has come back and the program is idle
   task automatic drain();
      req_tvalid <= 1'b0;
      // let the checker count the last transfer before looking at the backlog
      @(posedge clock);
      while (pending_samples != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic pick_idling();
      case ($urandom_range(0, 3))
         0: tx_gap_max = 0;
         1: tx_gap_max = 6;
         default: tx_gap_max = 48;
      endcase
      rx_steady = ($urandom_range(0, 3) == 0);
      rx_stall_max = $urandom_range(0, 1) ? 5 : 60;
   endtask

   function automatic logic [SAMPLE_W-1:0] pick_sample();
      case ($urandom_range(0, 9))
         0, 1, 2, 3: return SAMPLE_W'($urandom);
         4, 5: return SAMPLE_W'(int'($urandom_range(0, 512)) - 256);
         6: return $urandom_range(0, 1) ? SAMPLE_MAX : SAMPLE_MIN;
         default: begin
            // slowly wandering signal, the kind the filter passes
            drift_level = drift_level + int'($urandom_range(0, 131072)) - 65536;
            if (drift_level > 8388607) drift_level = 8388607;
            if (drift_level < -8388608) drift_level = -8388608;
            return SAMPLE_W'(drift_level);
         end
      endcase
   endfunction

   function automatic logic [COEF_W-1:0] pick_coef();
      case ($urandom_range(0, 5))
         0: return COEF_MAX;
         1: return COEF_MIN;
         2: return '0;
         default: return COEF_W'($urandom);
      endcase
   endfunction

   task automatic send_random(input int count);
      repeat (count) send_sample(pick_sample());
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset coefficients; writes past the last register must change nothing
      write_coef(REG_SPARE_LO, COEF_W'($urandom));
      write_coef(REG_SPARE_HI, COEF_W'($urandom));
      tx_gap_max = 0;
      rx_steady = 1'b1;
      send_sample('0);
      send_sample(SAMPLE_W'(1));
      send_sample(SAMPLE_W'(-1));
      send_sample(SAMPLE_MAX);
      send_sample(SAMPLE_MIN);
      repeat (5) send_sample(SAMPLE_MAX);
      repeat (5) send_sample(SAMPLE_MIN);
      repeat (3) begin
         send_sample(SAMPLE_MAX);
         send_sample(SAMPLE_MIN);
      end
      send_sample(SAMPLE_W'(24'h555555));
      send_sample(SAMPLE_W'(24'haaaaaa));
      send_random(RANDOM_COUNT);
      drain();

      // unstable extremes: nodes must saturate and stay bounded
      pick_idling();
      load_coefs(COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX);
      send_random(RANDOM_COUNT);
      drain();

      pick_idling();
      load_coefs(COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN);
      send_random(RANDOM_COUNT);
      drain();

      pick_idling();
      load_coefs('0, '0, '0, '0, '0, '0);
      send_random(RANDOM_COUNT);
      drain();

      pick_idling();
      load_coefs(COEF_RESET.feedback1_high, COEF_RESET.feedback2_high, COEF_RESET.gain_mid,
                 COEF_RESET.feedback1_low, COEF_RESET.feedback2_low, COEF_RESET.gain_out);
      send_random(RANDOM_COUNT);
      drain();

      repeat (2) begin
         pick_idling();
         load_coefs(pick_coef(), pick_coef(), pick_coef(), pick_coef(), pick_coef(),
                    pick_coef());
         send_random(RANDOM_COUNT);
         drain();
      end

      $display("Sent %0d samples and checked %0d filtered results under the reset", samples_sent,
               checked_samples);
      $display("coefficients and %0d written settings, extremes and random ones included.",
               settings_used);
      if (failures == 0 && pending_samples == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   initial begin
      #20ms;
      $display("Timed out with %0d samples outstanding.", pending_samples);
      $display("== FAIL ==");
      $finish;
   end

endmodule
